>>> rtl/own_pkg.sv
// package for the overlap weight normalizer: request/result structs, op and register codes,
// fixed-point constants and divider handshake structs. no dependencies.

package own_pkg;

    // default store depth, one entry per vertex
    localparam int NUM_VERTICES_DEF = 16384;

    // fixed field widths
    localparam int VIDX_W  = 14;
    localparam int DIST_W  = 16;
    localparam int WGT_W   = 17;
    localparam int SUM_W   = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // divider: dividend and quotient widths, step counter width
    localparam int DVD_W   = 33;
    localparam int DIV_Q_W = 18;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    // fixed-point constants
    localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [SUM_W-1:0] SUM_MAX = 32'hFFFF_FFFF;

    // op codes
    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_EMIT  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS        = 1'd1;

    typedef struct packed {
        logic [1:0]        op;
        logic [VIDX_W-1:0] vertex_index;
        logic [DIST_W-1:0] distance;
        logic              searchlight_end;
    } item_t;

    typedef struct packed {
        logic [WGT_W-1:0] norm_weight;
        logic             zero_sum;
        logic             run_end;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [SUM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic               over;
        logic [DIV_Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/own_div.sv
// radix-2 restoring divider, one quotient bit per cycle, shared by both divisions.
// depends on own_pkg for the request/response structs and widths.

module own_div
    import own_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 over_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [DIV_Q_W-1:0]   dvd_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic [SUM_W-1:0]     dsr_reg;

    logic [SUM_W:0]       trial;
    logic [SUM_W:0]       diff;
    logic                 fits;

    // one shift-subtract step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIV_Q_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // control: start loads the upper dividend bits, then one step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= DIV_CNT_W'(DIV_Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == DIV_CNT_W'(1));
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    // datapath: quotient above DIV_Q_W bits is flagged as over
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            over_reg <= ({{(SUM_W - (DVD_W - DIV_Q_W)){1'b0}}, req.dividend[DVD_W-1:DIV_Q_W]}
                         >= req.divisor);
            rem_reg  <= {{(SUM_W - (DVD_W - DIV_Q_W)){1'b0}}, req.dividend[DVD_W-1:DIV_Q_W]};
            dvd_reg  <= req.dividend[DIV_Q_W-1:0];
            dsr_reg  <= req.divisor;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            dvd_reg <= {dvd_reg[DIV_Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.over     = over_reg;
    assign rsp.quotient = q_reg;

endmodule

>>> rtl/overlap_weight_normalizer_unit.sv
// overlap weight normalizer top level: per-vertex weight-sum memory, sequencer, result register.
// depends on own_pkg and own_div.
//
//   channel   signals                     direction   payload
//   item      item_valid / item_stall     in          item_t   (op, vertex, distance, end)
//   res       res_valid / res_stall       out         result_t (norm weight, zero sum, end)
//   cfg       cfg_we / cfg_index          in          cfg_data (distance_mode, radius)
//
// one item at a time: clear and op 3 finish in the idle state; accumulate passes load, a
// weight division in distance mode with a nonzero radius, and apply; emit adds the sum
// division and the result state, skipping the sum division when the vertex sum is zero, plus
// any wait for the output register. the shared divider retires one quotient bit per cycle over 18 bits.
// after reset a clearing pass writes zero to every memory entry, one per cycle, so items are
// stalled until it has finished; configuration writes are taken throughout.
// a finished result waits in the output register while the next request is accepted.

module overlap_weight_normalizer_unit
    import own_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output result_t              res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(NUM_VERTICES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_WDIV,
        S_APPLY,
        S_EDIV,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic               dmode_reg;
    logic [DIST_W-1:0]  radius_reg;
    logic               clr_active_reg;
    logic [IDX_W-1:0]   clr_addr_reg;

    logic [1:0]         op_reg;
    logic [IDX_W-1:0]   addr_reg;
    logic               idx_ok_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               end_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [WGT_W-1:0]   w_reg;
    logic [WGT_W-1:0]   q_reg;
    logic               zs_reg;
    logic               res_valid_reg;
    result_t            res_reg;

    logic [SUM_W-1:0]   mem [0:NUM_VERTICES-1];
    logic [SUM_W-1:0]   mem_rdata_reg;
    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_waddr;
    logic [SUM_W-1:0]   mem_wdata;

    logic               accept;
    logic               item_idx_ok;
    logic [IDX_W-1:0]   item_addr;
    logic               need_wdiv;
    logic [DIST_W-1:0]  dist_clamped;
    logic [DIST_W-1:0]  span;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic               res_free;
    logic [WGT_W-1:0]   q_sat;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    own_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // request handshake and index check
    assign item_stall  = clr_active_reg || (state_reg != S_IDLE);
    assign accept      = item_valid && !item_stall;
    assign item_idx_ok = ({{(32 - VIDX_W){1'b0}}, item.vertex_index} < 32'(NUM_VERTICES));
    assign item_addr   = IDX_W'(item.vertex_index);
    assign res_free    = !res_valid_reg || !res_stall;

    // entry weight pieces and saturating accumulate
    always_comb
    begin
        need_wdiv    = dmode_reg && (radius_reg != '0);
        dist_clamped = (dist_reg < radius_reg) ? dist_reg : radius_reg;
        span         = radius_reg - dist_clamped;
        sum_wide     = {1'b0, sum_reg} + {{(SUM_W + 1 - WGT_W){1'b0}}, w_reg};
        sum_sat      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        q_sat        = (div_rsp.over || (div_rsp.quotient > {1'b0, ONE_Q16}))
                       ? ONE_Q16 : div_rsp.quotient[WGT_W-1:0];
    end

    // divider requests: weight falloff first, then weight over sum
    always_comb
    begin
        div_req = '0;
        if (state_reg == S_LOAD)
        begin
            div_req.start    = need_wdiv;
            div_req.dividend = {1'b0, span, 16'h0000};
            div_req.divisor  = {{(SUM_W - DIST_W){1'b0}}, radius_reg};
        end
        else if (state_reg == S_APPLY)
        begin
            div_req.start    = (op_reg == OP_EMIT) && (sum_reg != '0);
            div_req.dividend = {w_reg, 16'h0000};
            div_req.divisor  = sum_reg;
        end
    end

    // memory port control: clearing pass, accumulate write-back, single-entry clear
    always_comb
    begin
        mem_re    = accept && item_idx_ok && ((item.op == OP_ACC) || (item.op == OP_EMIT));
        mem_we    = 1'b0;
        mem_waddr = item_addr;
        mem_wdata = '0;
        priority if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
        end
        else if ((state_reg == S_APPLY) && (op_reg == OP_ACC))
        begin
            mem_we    = idx_ok_reg;
            mem_waddr = addr_reg;
            mem_wdata = sum_sat;
        end
        else
        begin
            mem_we = accept && item_idx_ok && (item.op == OP_CLEAR);
        end
    end

    // vertex sum memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[item_addr];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dmode_reg  <= 1'b0;
            radius_reg <= 16'd2560;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISTANCE_MODE: dmode_reg  <= cfg_data[0];
                CFG_RADIUS:        radius_reg <= cfg_data;
                default:           dmode_reg  <= dmode_reg;
            endcase
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == IDX_W'(NUM_VERTICES - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // sequencer with item and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            op_reg        <= OP_NONE;
            idx_ok_reg    <= 1'b0;
            addr_reg      <= '0;
            dist_reg      <= '0;
            end_reg       <= 1'b0;
            sum_reg       <= '0;
            w_reg         <= '0;
            q_reg         <= '0;
            zs_reg        <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_valid_reg && !res_stall && (state_reg != S_OUT))
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= item.op;
                        addr_reg   <= item_addr;
                        idx_ok_reg <= item_idx_ok;
                        dist_reg   <= item.distance;
                        end_reg    <= item.searchlight_end;
                        if ((item.op == OP_ACC) || (item.op == OP_EMIT))
                        begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_LOAD:
                begin
                    sum_reg <= idx_ok_reg ? mem_rdata_reg : '0;
                    w_reg   <= dmode_reg ? '0 : ONE_Q16;
                    state_reg <= need_wdiv ? S_WDIV : S_APPLY;
                end
                S_WDIV:
                begin
                    if (div_rsp.done)
                    begin
                        w_reg     <= div_rsp.quotient[WGT_W-1:0];
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (op_reg == OP_ACC)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (sum_reg == '0)
                    begin
                        q_reg     <= '0;
                        zs_reg    <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_EDIV;
                    end
                end
                S_EDIV:
                begin
                    if (div_rsp.done)
                    begin
                        q_reg     <= q_sat;
                        zs_reg    <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (res_free)
                    begin
                        res_reg.norm_weight <= q_reg;
                        res_reg.zero_sum    <= zs_reg;
                        res_reg.run_end     <= end_reg;
                        res_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // no request is processed while the clearing pass runs
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (state_reg == S_IDLE))
        else $error("sequencer left idle during clearing pass");

    // the shared divider is never restarted while busy
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // accumulate write-back only for an in-range vertex
    a_wb_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !clr_active_reg && (state_reg == S_APPLY)) |-> idx_ok_reg)
        else $error("write-back to out-of-range vertex");

    // a new result is only loaded from the result state
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside result state");

endmodule

>>> test/overlap_weight_normalizer_unit_tb.sv
// self-checking testbench for overlap_weight_normalizer_unit: directed and random requests
// checked against a cycle-free model of the per-vertex weight sums.
// depends on own_pkg and the overlap_weight_normalizer_unit rtl.
`timescale 1ns / 100ps

module overlap_weight_normalizer_unit_tb;
    import own_pkg::*;

    localparam int NUM_VERTICES  = NUM_VERTICES_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int PRINT_LIMIT   = 200;
    localparam int POOL_SIZE     = 32;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_BUDGET  = 220;
    localparam int PILE_ACCUMS   = 32;

    typedef struct {
        item_t req;
        bit    drain;
    } request_entry_t;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    item_t                item       = '0;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    result_t              res;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;

    // model state: weight sums and register copies
    logic [SUM_W-1:0]  weight_sum [NUM_VERTICES];
    logic              distance_mode_q = 1'b0;
    logic [DIST_W-1:0] radius_q        = 16'd2560;

    request_entry_t    request_queue [$];
    result_t           due_results [$];
    logic [VIDX_W-1:0] hot_vertex [POOL_SIZE];

    int  queued_count   = 0;
    int  accepted_count = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  drain_hold     = 1'b0;

    overlap_weight_normalizer_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // entry weight in q1.16 from the current mode and radius
    function automatic logic [WGT_W-1:0] falloff_weight(input logic [DIST_W-1:0] dist_val);
        logic [DIST_W-1:0] d;
        logic [31:0]       span;
        if (!distance_mode_q)
            return ONE_Q16;
        if (radius_q == '0)
            return '0;
        d = (dist_val < radius_q) ? dist_val : radius_q;
        span = {radius_q - d, 16'h0000};
        return WGT_W'(span / {16'h0000, radius_q});
    endfunction

    // update the sums for one request and queue the normalized weight it yields
    function automatic void normalize_request(input item_t req);
        logic [WGT_W-1:0] w;
        logic [SUM_W-1:0] sum;
        logic [SUM_W:0]   total;
        logic [DVD_W-1:0] quot;
        logic             in_range;
        result_t          r;
        in_range = int'(req.vertex_index) < NUM_VERTICES;
        w = falloff_weight(req.distance);
        case (req.op)
            OP_ACC:
            begin
                if (in_range)
                begin
                    total = {1'b0, weight_sum[req.vertex_index]} + (SUM_W + 1)'(w);
                    weight_sum[req.vertex_index] = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
                end
            end
            OP_CLEAR:
            begin
                if (in_range)
                    weight_sum[req.vertex_index] = '0;
            end
            OP_EMIT:
            begin
                sum = in_range ? weight_sum[req.vertex_index] : '0;
                r.run_end = req.searchlight_end;
                if (sum == '0)
                begin
                    r.zero_sum    = 1'b1;
                    r.norm_weight = '0;
                end
                else
                begin
                    quot = {w, 16'h0000} / {1'b0, sum};
                    r.zero_sum    = 1'b0;
                    r.norm_weight = (quot > DVD_W'(ONE_Q16)) ? ONE_Q16 : quot[WGT_W-1:0];
                end
                due_results.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        // keep the log short when things go badly wrong
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycle_count, what, got, want);
    endtask

    task automatic queue_request(input logic [1:0] op, input logic [VIDX_W-1:0] vtx,
                                 input logic [DIST_W-1:0] dist_val, input logic last,
                                 input bit drain);
        request_entry_t entry;
        entry.req.op              = op;
        entry.req.vertex_index    = vtx;
        entry.req.distance        = dist_val;
        entry.req.searchlight_end = last;
        entry.drain               = drain;
        request_queue.push_back(entry);
        queued_count++;
    endtask

    // register write through the configuration port, mirrored into the model
    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DISTANCE_MODE: distance_mode_q = value[0];
            CFG_RADIUS:        radius_q = value[DIST_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_mode(input logic mode, input logic [DIST_W-1:0] rad);
        write_config(CFG_DISTANCE_MODE, CFG_W'(mode));
        write_config(CFG_RADIUS, rad);
    endtask

    // wait until every request is taken and every result is back, then let the block settle
    task automatic wait_idle();
        while (accepted_count != queued_count || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [VIDX_W-1:0] pick_vertex();
        if ($urandom_range(99) < 80)
            return hot_vertex[$urandom_range(POOL_SIZE - 1)];
        return VIDX_W'($urandom);
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return DIST_W'($urandom);
        if (roll < 30)
            return '0;
        if (roll < 40)
            return radius_q;
        if (roll < 50)
            return DIST_W'($urandom_range(radius_q, 16'hFFFF));
        return DIST_W'($urandom_range(0, radius_q));
    endfunction

    // mostly whole searchlights (accumulate pass, then emit pass), with clears and noise
    task automatic queue_searchlights(input int budget);
        logic [VIDX_W-1:0] vtx [8];
        logic [DIST_W-1:0] dst [8];
        logic [DIST_W-1:0] emit_dist;
        int                counted;
        int                n;
        int unsigned       roll;
        bit                drain_done;
        counted = 0;
        drain_done = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            hot_vertex[i] = VIDX_W'($urandom);
        hot_vertex[0] = '0;
        hot_vertex[1] = '1;
        while (counted < budget)
        begin
            roll = $urandom_range(99);
            if (roll < 75)
            begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                begin
                    vtx[k] = pick_vertex();
                    dst[k] = pick_distance();
                end
                for (int k = 0; k < n; k++)
                    queue_request(OP_ACC, vtx[k], dst[k], k == n - 1,
                                  !drain_done && k == 0 && counted >= budget / 2);
                if (counted >= budget / 2)
                    drain_done = 1'b1;
                for (int k = 0; k < n; k++)
                begin
                    emit_dist = ($urandom_range(9) == 0) ? pick_distance() : dst[k];
                    queue_request(OP_EMIT, vtx[k], emit_dist, k == n - 1, 1'b0);
                end
                counted += 2 * n;
            end
            else if (roll < 83)
            begin
                queue_request(OP_CLEAR, pick_vertex(), DIST_W'($urandom), 1'($urandom), 1'b0);
                counted++;
            end
            else if (roll < 88)
                queue_request(OP_NONE, VIDX_W'($urandom), DIST_W'($urandom), 1'($urandom), 1'b0);
            else
            begin
                queue_request(2'($urandom_range(2)), pick_vertex(), pick_distance(),
                              1'($urandom), 1'b0);
                counted++;
            end
        end
    endtask

    // request driver: holds a stalled request, otherwise takes the next queued one
    always @(posedge clk)
    begin : drive_requests
        request_entry_t entry;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            drain_hold = 1'b0;
        end
        else if (!item_valid || !item_stall)
        begin
            // a flagged request first waits for every due result
            if (request_queue.size() > 0 && request_queue[0].drain)
            begin
                if (drain_hold && due_results.size() == 0)
                begin
                    entry = request_queue.pop_front();
                    entry.drain = 1'b0;
                    request_queue.push_front(entry);
                    drain_hold = 1'b0;
                end
                else
                    drain_hold = 1'b1;
            end
            if (request_queue.size() > 0 && !request_queue[0].drain
                && $urandom_range(99) >= send_idle_pct)
            begin
                entry = request_queue.pop_front();
                item_valid <= 1'b1;
                item       <= entry.req;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // predict on accepted requests, check accepted results
    always @(posedge clk)
    begin : watch_channels
        result_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                normalize_request(item);
                accepted_count++;
            end
            if (res_valid && !res_stall)
            begin
                if (due_results.size() == 0)
                    report_mismatch("result with none due", 32'(res), 32'd0);
                else
                begin
                    want = due_results.pop_front();
                    if (res.norm_weight !== want.norm_weight)
                        report_mismatch("norm_weight", 32'(res.norm_weight),
                                        32'(want.norm_weight));
                    if (res.zero_sum !== want.zero_sum)
                        report_mismatch("zero_sum", 32'(res.zero_sum), 32'(want.zero_sum));
                    if (res.run_end !== want.run_end)
                        report_mismatch("run_end", 32'(res.run_end), 32'(want.run_end));
                end
            end
        end
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int          phase_mode [PHASE_COUNT];
        int unsigned phase_radius [PHASE_COUNT];
        int          idle_send [4];
        int          idle_recv [4];
        for (int i = 0; i < NUM_VERTICES; i++)
            weight_sum[i] = '0;
        phase_mode   = '{0, 1, 1, 1, 0, 1, 1, 1};
        phase_radius = '{2560, 2560, 65535, 1, $urandom_range(1, 65535), 0,
                         $urandom_range(1, 65535), $urandom_range(1, 1024)};
        idle_send = '{0, 79, 0, 7};
        idle_recv = '{0, 0, 79, 7};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // uniform weights: empty vertex, plain ratio, lone entry, clear, unused op
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        set_mode(1'b0, 16'd2560);
        queue_request(OP_EMIT, 14'd0, 16'd0, 1'b1, 1'b0);
        queue_request(OP_ACC, 14'd0, 16'd0, 1'b0, 1'b0);
        queue_request(OP_ACC, 14'd0, 16'hFFFF, 1'b0, 1'b0);
        queue_request(OP_EMIT, 14'd0, 16'd1234, 1'b0, 1'b0);
        queue_request(OP_ACC, 14'h3FFF, 16'hFFFF, 1'b1, 1'b0);
        queue_request(OP_EMIT, 14'h3FFF, 16'd0, 1'b1, 1'b0);
        queue_request(OP_CLEAR, 14'd0, 16'd0, 1'b0, 1'b0);
        queue_request(OP_EMIT, 14'd0, 16'd0, 1'b0, 1'b0);
        queue_request(OP_NONE, 14'd5, 16'hFFFF, 1'b1, 1'b0);
        wait_idle();

        // distance falloff: clamp beyond the radius, sum below the weight after a mode change
        set_mode(1'b1, 16'd2560);
        queue_request(OP_ACC, 14'd1, 16'd0, 1'b0, 1'b0);
        queue_request(OP_ACC, 14'd1, 16'd1280, 1'b0, 1'b0);
        queue_request(OP_ACC, 14'd1, 16'hFFFF, 1'b1, 1'b0);
        queue_request(OP_EMIT, 14'd1, 16'd1280, 1'b0, 1'b0);
        queue_request(OP_EMIT, 14'd1, 16'd0, 1'b0, 1'b0);
        queue_request(OP_EMIT, 14'd1, 16'hFFFF, 1'b1, 1'b0);
        queue_request(OP_ACC, 14'd2, 16'd2559, 1'b0, 1'b0);
        queue_request(OP_EMIT, 14'd2, 16'd0, 1'b1, 1'b0);
        queue_request(OP_EMIT, 14'h3FFF, 16'd2560, 1'b0, 1'b0);
        wait_idle();

        // zero radius gives zero weight
        set_mode(1'b1, 16'd0);
        queue_request(OP_ACC, 14'd3, 16'd0, 1'b0, 1'b0);
        queue_request(OP_EMIT, 14'd3, 16'd0, 1'b1, 1'b0);
        queue_request(OP_EMIT, 14'd1, 16'd0, 1'b0, 1'b0);
        wait_idle();

        // widest and narrowest radius
        set_mode(1'b1, 16'hFFFF);
        queue_request(OP_ACC, 14'd4, 16'hFFFF, 1'b0, 1'b0);
        queue_request(OP_ACC, 14'd4, 16'd0, 1'b1, 1'b0);
        queue_request(OP_EMIT, 14'd4, 16'h8000, 1'b0, 1'b0);
        wait_idle();
        set_mode(1'b1, 16'd1);
        queue_request(OP_EMIT, 14'd4, 16'd0, 1'b0, 1'b0);
        queue_request(OP_EMIT, 14'd4, 16'd1, 1'b1, 1'b0);
        wait_idle();

        // pile many entries onto one vertex back to back
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_mode(1'b0, 16'd1);
        for (int i = 0; i < PILE_ACCUMS; i++)
            queue_request(OP_ACC, 14'd7, DIST_W'($urandom), 1'($urandom), 1'b0);
        queue_request(OP_EMIT, 14'd7, 16'd0, 1'b0, 1'b0);
        queue_request(OP_ACC, 14'd7, 16'd0, 1'b0, 1'b0);
        queue_request(OP_EMIT, 14'd7, 16'hFFFF, 1'b1, 1'b0);
        queue_request(OP_CLEAR, 14'd7, 16'd0, 1'b0, 1'b0);
        queue_request(OP_EMIT, 14'd7, 16'd0, 1'b0, 1'b0);
        wait_idle();

        // random searchlights over several settings and idle profiles
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_mode(1'(phase_mode[p]), DIST_W'(phase_radius[p]));
            send_idle_pct  = idle_send[p % 4];
            recv_stall_pct = idle_recv[p % 4];
            queue_searchlights(PHASE_BUDGET);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
